### design/gbirq_pkg.sv
// Shared codes, defaults and memory port control for the GPIO bank block.
package gbirq_pkg;

  localparam int GB_NUM_BANKS     = 4;
  localparam int GB_PINS_PER_BANK = 32;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_READ   = 2'd1,
    OP_WRITE  = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    REG_OE      = 4'd0,
    REG_DATAIN  = 4'd1,
    REG_DATAOUT = 4'd2,
    REG_SETOUT  = 4'd3,
    REG_CLROUT  = 4'd4,
    REG_STATUS  = 4'd5,
    REG_IRQSET  = 4'd6,
    REG_IRQCLR  = 4'd7,
    REG_RISE    = 4'd8,
    REG_FALL    = 4'd9,
    REG_LOW     = 4'd10,
    REG_HIGH    = 4'd11
  } reg_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctrl_t;

endpackage

### design/gpio_banks_with_edge_level_irq.sv
// GPIO banks with edge/level interrupt detection: read-modify-write pipeline over bank state.
// Stage 1 registers each item with its bank state read; the result is registered from stage 1.
// Throughput: one item per cycle unless the result stalls; state memory is read and written
// once per valid-bank item; a write-back register forwards the last write to the next read.
// Reset: control and interrupt flags clear at once; each bank reads as its reset value
// (all pins input, everything else zero) until first written, with no clearing pass.
module gpio_banks_with_edge_level_irq
  import gbirq_pkg::*;
#(
  parameter int NUM_BANKS     = GB_NUM_BANKS,
  parameter int PINS_PER_BANK = GB_PINS_PER_BANK
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  op,
  input  logic [1:0]  bank_select,
  input  logic [3:0]  reg_index,
  input  logic [31:0] write_data,
  input  logic [31:0] pin_levels,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [31:0] read_data,
  output logic [3:0]  irq_lines,
  output logic [31:0] out_levels,
  output logic [31:0] out_disable
);

  localparam int PW = PINS_PER_BANK;
  localparam int AW = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;

  typedef struct packed {
    logic [PW-1:0] dir;
    logic [PW-1:0] outd;
    logic [PW-1:0] last;
    logic [PW-1:0] pend;
    logic [PW-1:0] mask;
    logic [PW-1:0] rise;
    logic [PW-1:0] fall;
    logic [PW-1:0] low;
    logic [PW-1:0] high;
  } bank_state_t;

  localparam int SW = $bits(bank_state_t);
  localparam bank_state_t STATE_RESET = '{
    dir: {PW{1'b1}}, outd: '0, last: '0, pend: '0, mask: '0,
    rise: '0, fall: '0, low: '0, high: '0
  };

  // stage 1: item waiting on its memory read
  logic          s1_valid;
  op_t           s1_op;
  reg_t          s1_reg;
  logic [AW-1:0] s1_bank;
  logic          s1_bank_ok;
  logic [PW-1:0] s1_wd;
  logic [PW-1:0] s1_lv;
  logic          s1_adv;
  logic          accept;
  logic          bank_ok;

  // last write-back, for a read issued in the same cycle as that write
  logic          fwd_valid;
  logic [AW-1:0] fwd_bank;
  bank_state_t   fwd_data;

  mem_ctrl_t        mem_ctrl;
  logic [SW-1:0]    mem_rd_data;
  bank_state_t      cur;
  bank_state_t      nxt;
  logic [PW-1:0]    rd_val;
  logic [PW-1:0]    events;
  logic [NUM_BANKS-1:0] irq_flag;
  logic [NUM_BANKS-1:0] irq_flag_next;
  logic [NUM_BANKS+3:0] irq_pad;

  assign bank_ok    = 32'(bank_select) < NUM_BANKS;
  assign s1_adv     = s1_valid && (!result_valid || !result_stall);
  assign item_stall = s1_valid && !s1_adv;
  assign accept     = item_valid && !item_stall;

  assign mem_ctrl.rd_en = accept && bank_ok;
  assign mem_ctrl.wr_en = s1_adv && s1_bank_ok;

  gbirq_state_ram #(
    .WIDTH       (SW),
    .DEPTH       (NUM_BANKS),
    .AW          (AW),
    .RESET_VALUE (SW'(STATE_RESET))
  ) u_state_ram (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (mem_ctrl),
    .rd_addr (AW'(bank_select)),
    .wr_addr (s1_bank),
    .wr_data (SW'(nxt)),
    .rd_data (mem_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op      <= op_t'(op);
      s1_reg     <= reg_t'(reg_index);
      s1_bank    <= AW'(bank_select);
      s1_bank_ok <= bank_ok;
      s1_wd      <= write_data[PW-1:0];
      s1_lv      <= pin_levels[PW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (mem_ctrl.wr_en) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_ctrl.wr_en) begin
      fwd_bank <= s1_bank;
      fwd_data <= nxt;
    end
  end

  assign cur    = (fwd_valid && fwd_bank == s1_bank) ? fwd_data : bank_state_t'(mem_rd_data);
  assign events = (~cur.last & s1_lv & cur.rise) | (cur.last & ~s1_lv & cur.fall) |
                  (~s1_lv & cur.low) | (s1_lv & cur.high);

  always_comb begin
    nxt    = cur;
    rd_val = '0;
    case (s1_op)
      OP_SAMPLE: begin
        nxt.pend = cur.pend | events;
        nxt.last = s1_lv;
      end
      OP_READ: begin
        case (s1_reg)
          REG_OE:      rd_val = cur.dir;
          REG_DATAIN:  rd_val = cur.last;
          REG_DATAOUT: rd_val = cur.outd;
          REG_SETOUT:  rd_val = cur.outd;
          REG_CLROUT:  rd_val = cur.outd;
          REG_STATUS:  rd_val = cur.pend & cur.mask;
          REG_IRQSET:  rd_val = cur.mask;
          REG_IRQCLR:  rd_val = cur.mask;
          REG_RISE:    rd_val = cur.rise;
          REG_FALL:    rd_val = cur.fall;
          REG_LOW:     rd_val = cur.low;
          REG_HIGH:    rd_val = cur.high;
          default:     rd_val = '0;
        endcase
      end
      OP_WRITE: begin
        case (s1_reg)
          REG_OE:      nxt.dir  = s1_wd;
          REG_DATAOUT: nxt.outd = s1_wd;
          REG_SETOUT:  nxt.outd = cur.outd | s1_wd;
          REG_CLROUT:  nxt.outd = cur.outd & ~s1_wd;
          REG_STATUS:  nxt.pend = cur.pend & ~s1_wd;
          REG_IRQSET:  nxt.mask = cur.mask | s1_wd;
          REG_IRQCLR:  nxt.mask = cur.mask & ~s1_wd;
          REG_RISE:    nxt.rise = s1_wd;
          REG_FALL:    nxt.fall = s1_wd;
          REG_LOW:     nxt.low  = s1_wd;
          REG_HIGH:    nxt.high = s1_wd;
          default:     nxt      = cur;
        endcase
      end
      default: nxt = cur;
    endcase
  end

  // interrupt line per bank kept in flops so all banks are visible every cycle
  always_comb begin
    irq_flag_next = irq_flag;
    if (s1_bank_ok) begin
      irq_flag_next[s1_bank] = |(nxt.pend & nxt.mask);
    end
  end

  assign irq_pad = {4'b0000, irq_flag_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      irq_flag <= '0;
    end else if (s1_adv) begin
      irq_flag <= irq_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_adv) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      read_data   <= s1_bank_ok ? 32'(rd_val) : 32'd0;
      irq_lines   <= irq_pad[3:0];
      out_levels  <= s1_bank_ok ? 32'(nxt.outd) : 32'd0;
      out_disable <= s1_bank_ok ? 32'(nxt.dir) : 32'({PW{1'b1}});
    end
  end

  a_hold_stage: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_bank) && $stable(s1_op)))
    else $error("stage 1 item changed while held");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> result_valid)
    else $error("advanced item produced no result");

  a_accept_slot: assert property (@(posedge clk) disable iff (rst)
    (accept && s1_valid) |-> s1_adv)
    else $error("item transfer into an occupied stage");

  a_writeback: assert property (@(posedge clk) disable iff (rst)
    mem_ctrl.wr_en |=> (fwd_valid && fwd_bank == $past(s1_bank)))
    else $error("write-back register not tracking last write");

endmodule

### design/gbirq_state_ram.sv
// Per-bank state memory: one write port, one registered read port, written flags.
module gbirq_state_ram
  import gbirq_pkg::*;
#(
  parameter int                 WIDTH       = 288,
  parameter int                 DEPTH       = 4,
  parameter int                 AW          = 2,
  parameter logic [WIDTH-1:0]   RESET_VALUE = '0
) (
  input  logic             clk,
  input  logic             rst,
  input  mem_ctrl_t        ctrl,
  input  logic [AW-1:0]    rd_addr,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] written;
  logic [WIDTH-1:0] rd_q;
  logic             rd_written;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctrl.rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // an entry never written reads as its reset value
  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (ctrl.wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (ctrl.rd_en) begin
        rd_written <= written[rd_addr];
      end
    end
  end

  assign rd_data = rd_written ? rd_q : RESET_VALUE;

endmodule
